FILE: rtl/core/pfpv_pkg.sv
// ----------------------------------------------------------------------------
// pfpv_pkg
// Shared types, constants and tables for the person-follow velocity controller
// ----------------------------------------------------------------------------
package pfpv_pkg;

    localparam int COORD_FRAC_BITS_DEFAULT = 10;
    localparam int ATAN_ITERATIONS_DEFAULT = 16;

    localparam int PI_Q12      = 12868;
    localparam int PI6_Q12     = 2145;
    localparam int PI12_Q12    = 1072;
    localparam int HALF_PI_Q16 = 102944;
    localparam int BACKOFF_Q12 = -819;

    localparam logic [13:0] CRUISE_SPEED_RESET    = 14'd819;
    localparam logic [14:0] TURN_RATE_LIMIT_RESET = 15'd4096;
    localparam logic [15:0] GAIN_P_RESET          = 16'd6554;
    localparam logic [15:0] GAIN_I_RESET          = 16'd205;
    localparam logic [15:0] GAIN_D_RESET          = 16'd41;

    typedef enum logic [2:0] {
        ACT_NO_MOVE      = 3'd0,
        ACT_BACK_OFF     = 3'd1,
        ACT_DEAD_ZONE    = 3'd2,
        ACT_ROTATE       = 3'd3,
        ACT_STRAIGHT     = 3'd4,
        ACT_CURVE        = 3'd5,
        ACT_DEFAULT_STOP = 3'd6
    } action_t;

    typedef enum logic [2:0] {
        CFG_CRUISE_SPEED    = 3'd0,
        CFG_TURN_RATE_LIMIT = 3'd1,
        CFG_GAIN_P          = 3'd2,
        CFG_GAIN_I          = 3'd3,
        CFG_GAIN_D          = 3'd4
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_HEAD,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_SCALE,
        ST_RECIP,
        ST_FINISH
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CORDIC,
        OP_HEAD,
        OP_MUL_P,
        OP_MUL_I,
        OP_MUL_D,
        OP_SCALE,
        OP_RECIP,
        OP_FINISH
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic band;
    } status_t;

    // atan(2^-i) in Q.16 rad
    function automatic logic [15:0] atan_q16(input logic [4:0] i);
        logic [15:0] a;
        case (i)
            5'd0:    a = 16'd51472;
            5'd1:    a = 16'd30386;
            5'd2:    a = 16'd16055;
            5'd3:    a = 16'd8150;
            5'd4:    a = 16'd4091;
            5'd5:    a = 16'd2047;
            5'd6:    a = 16'd1024;
            5'd7:    a = 16'd512;
            default: a = 16'(32'd65536 >> i);
        endcase
        return a;
    endfunction

endpackage

FILE: rtl/core/pfpv_ctrl.sv
// ----------------------------------------------------------------------------
// pfpv_ctrl
// Sequencer: input handshake, cordic iteration count, pid steps, output valid
// ----------------------------------------------------------------------------
module pfpv_ctrl #(
    parameter int ATAN_ITERATIONS = pfpv_pkg::ATAN_ITERATIONS_DEFAULT,
    localparam int IW = $clog2(ATAN_ITERATIONS)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  pfpv_pkg::status_t  status,
    output pfpv_pkg::cmd_t     cmd,
    output logic [IW-1:0]      iter
);

    localparam logic [IW-1:0] LAST_ITER = IW'(ATAN_ITERATIONS - 1);

    pfpv_pkg::state_t state_reg, state_next;
    logic [IW-1:0]    iter_reg, iter_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pfpv_pkg::ST_IDLE;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        iter_next      = iter_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd.op         = pfpv_pkg::OP_NONE;
        s_tready       = 1'b0;
        case (state_reg)
            pfpv_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.op     = pfpv_pkg::OP_LOAD;
                    iter_next  = '0;
                    state_next = status.band ? pfpv_pkg::ST_CORDIC : pfpv_pkg::ST_FINISH;
                end
            end
            pfpv_pkg::ST_CORDIC:
            begin
                cmd.op = pfpv_pkg::OP_CORDIC;
                if (iter_reg == LAST_ITER)
                begin
                    iter_next  = '0;
                    state_next = pfpv_pkg::ST_HEAD;
                end
                else
                begin
                    iter_next = iter_reg + 1'b1;
                end
            end
            pfpv_pkg::ST_HEAD:
            begin
                cmd.op     = pfpv_pkg::OP_HEAD;
                state_next = pfpv_pkg::ST_MUL_P;
            end
            pfpv_pkg::ST_MUL_P:
            begin
                cmd.op     = pfpv_pkg::OP_MUL_P;
                state_next = pfpv_pkg::ST_MUL_I;
            end
            pfpv_pkg::ST_MUL_I:
            begin
                cmd.op     = pfpv_pkg::OP_MUL_I;
                state_next = pfpv_pkg::ST_MUL_D;
            end
            pfpv_pkg::ST_MUL_D:
            begin
                cmd.op     = pfpv_pkg::OP_MUL_D;
                state_next = pfpv_pkg::ST_SCALE;
            end
            pfpv_pkg::ST_SCALE:
            begin
                cmd.op     = pfpv_pkg::OP_SCALE;
                state_next = pfpv_pkg::ST_RECIP;
            end
            pfpv_pkg::ST_RECIP:
            begin
                cmd.op     = pfpv_pkg::OP_RECIP;
                state_next = pfpv_pkg::ST_FINISH;
            end
            pfpv_pkg::ST_FINISH:
            begin
                // wait for the output register to drain
                if (!out_valid_reg || m_tready)
                begin
                    cmd.op         = pfpv_pkg::OP_FINISH;
                    out_valid_next = 1'b1;
                    state_next     = pfpv_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pfpv_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign iter     = iter_reg;

endmodule

FILE: rtl/core/pfpv_datapath.sv
// ----------------------------------------------------------------------------
// pfpv_datapath
// Config registers, cordic atan2, heading pid with shared steps, output register
// ----------------------------------------------------------------------------
module pfpv_datapath #(
    parameter int COORD_FRAC_BITS = pfpv_pkg::COORD_FRAC_BITS_DEFAULT,
    parameter int ATAN_ITERATIONS = pfpv_pkg::ATAN_ITERATIONS_DEFAULT,
    localparam int IW = $clog2(ATAN_ITERATIONS)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pfpv_pkg::cmd_t     cmd,
    input  logic [IW-1:0]      iter,
    output pfpv_pkg::status_t  status,
    input  logic [19:0]        goal_x,
    input  logic [19:0]        goal_y,
    input  logic [19:0]        person_distance,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output logic [15:0]        linear_speed,
    output logic [15:0]        angular_speed,
    output logic [2:0]         action
);

    localparam int F = COORD_FRAC_BITS;
    localparam logic signed [20:0] T15 = 21'(3 << (F - 1));
    localparam logic signed [20:0] T30 = 21'(3 << F);
    localparam logic signed [20:0] T45 = 21'(9 << (F - 1));
    localparam logic signed [20:0] T32 = 21'(((32 << F) + 5) / 10);

    // configuration
    logic [13:0] cruise_reg;
    logic [14:0] lim_reg;
    logic [15:0] kp_reg, ki_reg, kd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cruise_reg <= pfpv_pkg::CRUISE_SPEED_RESET;
            lim_reg    <= pfpv_pkg::TURN_RATE_LIMIT_RESET;
            kp_reg     <= pfpv_pkg::GAIN_P_RESET;
            ki_reg     <= pfpv_pkg::GAIN_I_RESET;
            kd_reg     <= pfpv_pkg::GAIN_D_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pfpv_pkg::CFG_CRUISE_SPEED:    cruise_reg <= cfg_data[13:0];
                pfpv_pkg::CFG_TURN_RATE_LIMIT: lim_reg    <= cfg_data[14:0];
                pfpv_pkg::CFG_GAIN_P:          kp_reg     <= cfg_data;
                pfpv_pkg::CFG_GAIN_I:          ki_reg     <= cfg_data;
                pfpv_pkg::CFG_GAIN_D:          kd_reg     <= cfg_data;
                default:                       ;
            endcase
        end
    end

    // distance classification
    logic signed [20:0] pdist;
    pfpv_pkg::action_t  act_in;
    logic               band_in;

    always_comb
    begin
        pdist   = 21'($signed(person_distance));
        band_in = 1'b0;
        if (pdist <= 0 || pdist < T15 || pdist > T45)
            act_in = pfpv_pkg::ACT_NO_MOVE;
        else if (pdist > T32)
            act_in = pfpv_pkg::ACT_BACK_OFF;
        else if (pdist >= T30)
            act_in = pfpv_pkg::ACT_DEAD_ZONE;
        else if (pdist > T15)
        begin
            act_in  = pfpv_pkg::ACT_CURVE;
            band_in = 1'b1;
        end
        else
            act_in = pfpv_pkg::ACT_DEFAULT_STOP;
    end

    assign status.band = band_in;

    pfpv_pkg::action_t  act_reg;
    logic               band_reg;
    logic [17:0]        ldiff_reg;
    logic signed [22:0] x_reg, y_reg;
    logic signed [19:0] z_reg;
    logic signed [15:0] e_reg;
    logic signed [16:0] diff_reg;
    logic signed [31:0] integ_reg;
    logic signed [15:0] prev_reg;
    logic signed [51:0] acc_reg;
    logic [18:0]        b_reg;
    logic [15:0]        w_reg;
    logic [15:0]        qa_reg;
    logic [15:0]        qw_reg;
    logic signed [15:0] lin_reg, ang_reg;
    logic [2:0]         out_act_reg;

    // pre-rotation into the right half plane
    logic signed [22:0] gx, gy, x0, y0;
    logic signed [19:0] z0;

    always_comb
    begin
        gx = 23'($signed(goal_x));
        gy = 23'($signed(goal_y));
        x0 = gx;
        y0 = gy;
        z0 = '0;
        if (gx < 0)
        begin
            if (gy >= 0)
            begin
                x0 = gy;
                y0 = -gx;
                z0 = 20'(pfpv_pkg::HALF_PI_Q16);
            end
            else
            begin
                x0 = -gy;
                y0 = gx;
                z0 = -20'(pfpv_pkg::HALF_PI_Q16);
            end
        end
    end

    // one cordic micro-rotation
    logic signed [22:0] xs, ys, x1, y1;
    logic signed [19:0] z1, ang_step;

    always_comb
    begin
        xs       = x_reg >>> iter;
        ys       = y_reg >>> iter;
        ang_step = $signed({4'b0, pfpv_pkg::atan_q16(5'(iter))});
        x1       = x_reg;
        y1       = y_reg;
        z1       = z_reg;
        if (y_reg > 0)
        begin
            x1 = x_reg + ys;
            y1 = y_reg - xs;
            z1 = z_reg + ang_step;
        end
        else if (y_reg < 0)
        begin
            x1 = x_reg - ys;
            y1 = y_reg + xs;
            z1 = z_reg - ang_step;
        end
    end

    // heading error and integral
    logic signed [19:0] zr;
    logic signed [15:0] e_new;
    logic signed [32:0] s_wide;
    logic signed [31:0] s_new;

    always_comb
    begin
        zr = (z_reg + 20'sd8) >>> 4;
        if (zr > 20'(pfpv_pkg::PI_Q12))
            e_new = 16'(pfpv_pkg::PI_Q12);
        else if (zr < -20'(pfpv_pkg::PI_Q12))
            e_new = -16'(pfpv_pkg::PI_Q12);
        else
            e_new = zr[15:0];
        s_wide = 33'(integ_reg) + 33'(e_new);
        if (s_wide[32] != s_wide[31])
            s_new = s_wide[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
        else
            s_new = s_wide[31:0];
    end

    // pid products, one per step
    logic signed [32:0] prod_p;
    logic signed [48:0] prod_i;
    logic signed [33:0] prod_d;

    assign prod_p = $signed({1'b0, kp_reg}) * e_reg;
    assign prod_i = $signed({1'b0, ki_reg}) * integ_reg;
    assign prod_d = $signed({1'b0, kd_reg}) * diff_reg;

    // scaling ahead of the reciprocal multiplies
    logic signed [51:0] a_sh, a_cl;
    logic [31:0]        v_lin;

    always_comb
    begin
        a_sh = (acc_reg + 52'sd40960) >>> 14;
        if (a_sh > 52'sd163839)
            a_cl = 52'sd163839;
        else if (a_sh < -52'sd163840)
            a_cl = -52'sd163840;
        else
            a_cl = a_sh;
        v_lin = 32'(cruise_reg) * 32'(ldiff_reg);
    end

    logic [34:0] pa;
    logic [31:0] pw;

    assign pa = 35'(b_reg) * 35'd52428;
    assign pw = 32'(w_reg) * 32'd21845;

    // quotient correction and final selection
    logic [18:0]        ra;
    logic [15:0]        rw;
    logic [15:0]        qa_c, qw_c;
    logic signed [16:0] pid_raw, lim_s, pid;
    logic signed [15:0] ae;
    logic signed [15:0] lin_new, ang_new;
    logic [2:0]         act_new;

    always_comb
    begin
        ra      = b_reg - 19'(qa_reg * 19'd5);
        rw      = w_reg - 16'(qw_reg * 16'd3);
        qa_c    = (ra >= 19'd5) ? qa_reg + 16'd1 : qa_reg;
        qw_c    = (rw >= 16'd3) ? qw_reg + 16'd1 : qw_reg;
        pid_raw = $signed({1'b0, qa_c}) - 17'sd32768;
        lim_s   = $signed({2'b0, lim_reg});
        if (pid_raw > lim_s)
            pid = lim_s;
        else if (pid_raw < -lim_s)
            pid = -lim_s;
        else
            pid = pid_raw;
        ae      = e_reg < 0 ? -e_reg : e_reg;
        lin_new = '0;
        ang_new = '0;
        act_new = act_reg;
        if (band_reg)
        begin
            if (ae > 16'(pfpv_pkg::PI6_Q12))
            begin
                act_new = pfpv_pkg::ACT_ROTATE;
                ang_new = pid[15:0];
            end
            else if (ae < 16'(pfpv_pkg::PI12_Q12))
            begin
                act_new = pfpv_pkg::ACT_STRAIGHT;
                lin_new = $signed(qw_c);
            end
            else
            begin
                act_new = pfpv_pkg::ACT_CURVE;
                lin_new = $signed(qw_c);
                ang_new = pid[15:0];
            end
        end
        else if (act_reg == pfpv_pkg::ACT_BACK_OFF)
        begin
            lin_new = 16'(pfpv_pkg::BACKOFF_Q12);
        end
    end

    // controller state of the pid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= '0;
            prev_reg  <= '0;
        end
        else if (cmd.op == pfpv_pkg::OP_HEAD)
        begin
            integ_reg <= s_new;
            prev_reg  <= e_new;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            pfpv_pkg::OP_LOAD:
            begin
                act_reg   <= act_in;
                band_reg  <= band_in;
                ldiff_reg <= 18'(T30 - pdist);
                x_reg     <= x0;
                y_reg     <= y0;
                z_reg     <= z0;
            end
            pfpv_pkg::OP_CORDIC:
            begin
                x_reg <= x1;
                y_reg <= y1;
                z_reg <= z1;
            end
            pfpv_pkg::OP_HEAD:
            begin
                e_reg    <= e_new;
                diff_reg <= 17'(e_new) - 17'(prev_reg);
            end
            pfpv_pkg::OP_MUL_P:
            begin
                acc_reg <= (52'(prod_p) <<< 4) + (52'(prod_p) <<< 2);
            end
            pfpv_pkg::OP_MUL_I:
            begin
                acc_reg <= acc_reg + 52'(prod_i);
            end
            pfpv_pkg::OP_MUL_D:
            begin
                acc_reg <= acc_reg + (52'(prod_d) <<< 8) + (52'(prod_d) <<< 7)
                         + (52'(prod_d) <<< 4);
            end
            pfpv_pkg::OP_SCALE:
            begin
                b_reg <= 19'(a_cl + 52'sd163840);
                w_reg <= 16'(v_lin >> (F - 1));
            end
            pfpv_pkg::OP_RECIP:
            begin
                qa_reg <= pa[33:18];
                qw_reg <= pw[31:16];
            end
            pfpv_pkg::OP_FINISH:
            begin
                lin_reg     <= lin_new;
                ang_reg     <= ang_new;
                out_act_reg <= act_new;
            end
            default:
            begin
            end
        endcase
    end

    assign linear_speed  = lin_reg;
    assign angular_speed = ang_reg;
    assign action        = out_act_reg;

endmodule

FILE: rtl/core/person_follow_pid_velocity.sv
// ----------------------------------------------------------------------------
// person_follow_pid_velocity
// Person-following velocity command with cordic heading and pid turn rate
// ----------------------------------------------------------------------------
// One input transaction per control tick on s_*: goal point and person
// distance. One output transaction per input on m_*: linear and angular
// speed and an action code. The user writes registers through cfg_we/
// cfg_index/cfg_data only while no transaction is in flight; the block
// itself does not enforce this. From input acceptance, a person outside
// the following band goes straight to the finish step that loads the
// output register; inside the band the input passes the iterative cordic
// and the shared pid steps (head, P, I and D multiplies, scale and
// reciprocal) before the finish step. A new input is taken in the idle
// state after the output register is loaded, while the receiver keeps up.
// The output register holds a result until m_tready; a second result waits
// inside the block and s_tready stays low until the register drains.
// Reset clears the registers to their defaults, the pid integral and the
// previous heading error, and empties the output register.
// ----------------------------------------------------------------------------
module person_follow_pid_velocity #(
    parameter int COORD_FRAC_BITS = pfpv_pkg::COORD_FRAC_BITS_DEFAULT,
    parameter int ATAN_ITERATIONS = pfpv_pkg::ATAN_ITERATIONS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // goal_x, goal_y, person_distance, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // linear_speed, angular_speed, action, zero pad
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int IW = $clog2(ATAN_ITERATIONS);

    pfpv_pkg::cmd_t    cmd;
    pfpv_pkg::status_t status;
    logic [IW-1:0]     iter;
    logic [15:0]       linear_speed, angular_speed;
    logic [2:0]        action;

    pfpv_ctrl #(
        .ATAN_ITERATIONS(ATAN_ITERATIONS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd),
        .iter     (iter)
    );

    pfpv_datapath #(
        .COORD_FRAC_BITS(COORD_FRAC_BITS),
        .ATAN_ITERATIONS(ATAN_ITERATIONS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .iter            (iter),
        .status          (status),
        .goal_x          (s_tdata[19:0]),
        .goal_y          (s_tdata[39:20]),
        .person_distance (s_tdata[59:40]),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .linear_speed    (linear_speed),
        .angular_speed   (angular_speed),
        .action          (action)
    );

    assign m_tdata = {5'b0, action, angular_speed, linear_speed};

    // one transaction at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> action <= pfpv_pkg::ACT_DEFAULT_STOP)
        else $error("undefined action code");

    // stop codes carry no motion
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (action == pfpv_pkg::ACT_NO_MOVE || action == pfpv_pkg::ACT_DEAD_ZONE
        || action == pfpv_pkg::ACT_DEFAULT_STOP) |-> m_tdata[31:0] == 32'd0)
        else $error("motion commanded on a stop action");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && action == pfpv_pkg::ACT_STRAIGHT |-> angular_speed == 16'd0)
        else $error("turn commanded on straight action");

endmodule
